FILE: rtl/cbfd_pkg.sv
`default_nettype none

package cbfd_pkg;

  // datapath widths
  localparam int ACC_W       = 64;
  localparam int HALF_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int OUT_W       = 24;
  localparam int STEPS_W     = 6;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int SEEN_W      = 2;
  localparam int PC_W        = 3;

  // output scaling: floor(acc / (6 * 2^24)) = floor((acc >>> 25) / 3)
  localparam int ACC_SHIFT   = 25;
  localparam int T_W         = ACC_W - ACC_SHIFT;
  localparam int U_W         = 26;
  localparam int RECIP_SHIFT = 27;
  localparam logic [U_W-1:0]        RECIP        = U_W'(44739243);
  localparam logic signed [T_W-1:0] OUT_BIAS     = T_W'(25165824);
  localparam logic signed [T_W-1:0] OUT_BIAS_NEG = T_W'(-25165824);
  localparam logic [OUT_W-1:0]      OUT_MAX      = 24'h7FFFFF;
  localparam logic [OUT_W-1:0]      OUT_MIN      = 24'h800000;

  // register map
  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_STEPS = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_FRACTION = 4'd1;
  localparam logic [STEPS_W-1:0]     STEPS_RESET       = 6'd8;
  localparam logic [FRAC_W-1:0]      FRACTION_RESET    = 16'd8192;

  localparam logic [SEEN_W-1:0] SEEN_ONE  = 2'd1;
  localparam logic [SEEN_W-1:0] SEEN_FULL = 2'd3;

  // microprogram addresses
  localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] STEP_MUL_C = 3'd1;
  localparam logic [PC_W-1:0] STEP_MUL_B = 3'd2;
  localparam logic [PC_W-1:0] STEP_MUL_A = 3'd3;
  localparam logic [PC_W-1:0] STEP_ADD_A = 3'd4;
  localparam logic [PC_W-1:0] STEP_EMIT  = 3'd5;

  typedef enum logic [2:0] {
    L_NOP,
    L_MUL_C,
    L_MUL_B,
    L_MUL_A,
    L_ADD_A,
    L_STEP
  } lane_op_t;

  typedef enum logic [1:0] {
    S_NONE,
    S_H2,
    S_H3
  } scal_op_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_GOTO,
    J_ACCEPT,
    J_LOOP
  } jmp_t;

  typedef struct packed {
    scal_op_t        scal_op;
    lane_op_t        lane_op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
    logic            in_ready;
    logic            emit;
    logic            clr_k;
  } ucode_t;

  typedef struct packed {
    lane_op_t lane_op;
    scal_op_t scal_op;
    logic     in_ready;
    logic     emit;
    logic     last;
  } seq_ctrl_t;

  typedef struct packed {
    lane_op_t op;
    logic     load;
    logic     adv;
  } lane_ctrl_t;

  // control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{scal_op: S_NONE, lane_op: L_NOP, jmp: J_GOTO, target: STEP_IDLE,
          in_ready: 1'b0, emit: 1'b0, clr_k: 1'b0};
    unique case (pc)
      STEP_IDLE: begin
        w.jmp      = J_ACCEPT;
        w.target   = STEP_MUL_C;
        w.in_ready = 1'b1;
      end
      STEP_MUL_C: begin
        w.scal_op = S_H2;
        w.lane_op = L_MUL_C;
        w.jmp     = J_NEXT;
      end
      STEP_MUL_B: begin
        w.scal_op = S_H3;
        w.lane_op = L_MUL_B;
        w.jmp     = J_NEXT;
      end
      STEP_MUL_A: begin
        w.lane_op = L_MUL_A;
        w.jmp     = J_NEXT;
      end
      STEP_ADD_A: begin
        w.lane_op = L_ADD_A;
        w.jmp     = J_NEXT;
        w.clr_k   = 1'b1;
      end
      STEP_EMIT: begin
        w.lane_op = L_STEP;
        w.jmp     = J_LOOP;
        w.target  = STEP_IDLE;
        w.emit    = 1'b1;
      end
      default: begin
        w.jmp    = J_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cbfd_if.sv
`default_nettype none

// control point channel
interface cbfd_point_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          start_curve;

  modport source (output valid, point_x, point_y, start_curve, input ready);
  modport sink   (input valid, point_x, point_y, start_curve, output ready);
endinterface

// curve point channel
interface cbfd_curve_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] curve_x;
  logic signed [23:0] curve_y;
  logic               last_of_segment;

  modport source (output valid, curve_x, curve_y, last_of_segment, input ready);
  modport sink   (input valid, curve_x, curve_y, last_of_segment, output ready);
endinterface

// register write channel
interface cbfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/cbfd_seq.sv
`default_nettype none

module cbfd_seq import cbfd_pkg::*; #(
  parameter int MAX_SEGMENT_STEPS = 63
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   seg_start,
  input  logic                                   adv,
  input  logic [$clog2(MAX_SEGMENT_STEPS+1)-1:0] n_eff,
  output seq_ctrl_t                              ctrl
);

  localparam int CW = $clog2(MAX_SEGMENT_STEPS + 1);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [CW-1:0]   k;
  logic [CW-1:0]   k_next;
  logic            last;
  ucode_t          word;

  assign word = ucode_rom(pc);
  assign last = (k == n_eff);

  // step counter and loop counter
  always_comb begin
    pc_next = pc;
    k_next  = k;
    unique case (word.jmp)
      J_NEXT:   pc_next = pc + 1'b1;
      J_GOTO:   pc_next = word.target;
      J_ACCEPT: if (seg_start) pc_next = word.target;
      J_LOOP: begin
        if (adv) begin
          if (last) pc_next = word.target;
          else k_next = k + 1'b1;
        end
      end
      default:  pc_next = STEP_IDLE;
    endcase
    if (word.clr_k) k_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
      k  <= '0;
    end else begin
      pc <= pc_next;
      k  <= k_next;
    end
  end

  // control word decode
  always_comb begin
    ctrl.lane_op  = word.lane_op;
    ctrl.scal_op  = word.scal_op;
    ctrl.in_ready = word.in_ready;
    ctrl.emit     = word.emit;
    ctrl.last     = last;
  end

endmodule

`default_nettype wire

FILE: rtl/cbfd_lane.sv
`default_nettype none

module cbfd_lane import cbfd_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  lane_ctrl_t                    ctrl,
  input  logic [FRAC_W-1:0]             h,
  input  logic [HALF_W-1:0]             h2,
  input  logic [HALF_W-1:0]             h3,
  input  logic signed [COORD_WIDTH-1:0] point,
  output logic signed [OUT_W-1:0]       curve
);

  localparam int KW = COORD_WIDTH + 4;
  localparam int PW = KW + HALF_W + 1;

  logic signed [COORD_WIDTH-1:0] hist0, hist1, hist2;
  logic signed [KW-1:0] pe0, pe1, pe2, pe3;
  logic signed [KW-1:0] d12, s_b, t_c;
  logic signed [KW-1:0] coef_a, coef_b, coef_c, coef_d;
  logic signed [KW-1:0] mcoef;
  logic [HALF_W-1:0]    mfac;
  logic signed [PW-1:0] mprod;
  logic [ACC_W-1:0]     prod, prod6;
  logic [ACC_W-1:0]     acc0, acc1, acc2, acc3;
  logic signed [T_W-1:0] tval, tsum;
  logic [U_W-1:0]       s1_u;
  logic                 s1_hi, s1_lo;
  logic [2*U_W-1:0]     qprod;
  logic [OUT_W-1:0]     q;
  logic [OUT_W-1:0]     out_val;

  // basis matrix rows, scaled by six
  always_comb begin
    pe0 = KW'(hist0);
    pe1 = KW'(hist1);
    pe2 = KW'(hist2);
    pe3 = KW'(point);
    d12 = pe1 - pe2;
    s_b = pe0 - (pe1 <<< 1) + pe2;
    t_c = pe2 - pe0;
  end

  // history shift and coefficient capture on an input beat
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hist0  <= hist1;
      hist1  <= hist2;
      hist2  <= point;
      coef_a <= pe3 - pe0 + d12 + (d12 <<< 1);
      coef_b <= s_b + (s_b <<< 1);
      coef_c <= t_c + (t_c <<< 1);
      coef_d <= pe0 + (pe1 <<< 2) + pe2;
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      L_MUL_C: begin
        mcoef = coef_c;
        mfac  = HALF_W'(h);
      end
      L_MUL_B: begin
        mcoef = coef_b;
        mfac  = h2;
      end
      default: begin
        mcoef = coef_a;
        mfac  = h3;
      end
    endcase
  end

  assign mprod = mcoef * $signed({1'b0, mfac});
  assign prod6 = (prod << 2) + (prod << 1);

  always_ff @(posedge clk) begin
    prod <= ACC_W'(mprod);
  end

  // forward difference accumulators
  always_ff @(posedge clk) begin
    case (ctrl.op)
      L_MUL_B: begin
        acc0 <= {HALF_W'(coef_d), {HALF_W{1'b0}}};
        acc1 <= prod << FRAC_W;
      end
      L_MUL_A: begin
        acc1 <= acc1 + prod;
        acc2 <= prod << 1;
      end
      L_ADD_A: begin
        acc1 <= acc1 + prod;
        acc2 <= acc2 + prod6;
        acc3 <= prod6;
      end
      L_STEP: begin
        if (ctrl.adv) begin
          acc0 <= acc0 + acc1;
          acc1 <= acc1 + acc2;
          acc2 <= acc2 + acc3;
        end
      end
      default: ;
    endcase
  end

  // output scaling, first stage: shift, range check, bias
  assign tval = $signed(acc0[ACC_W-1:ACC_SHIFT]);
  assign tsum = tval + OUT_BIAS;

  // second stage: divide by three through the reciprocal
  always_comb begin
    qprod = s1_u * RECIP;
    q     = qprod[RECIP_SHIFT+OUT_W-1:RECIP_SHIFT];
    if (s1_hi) out_val = OUT_MAX;
    else if (s1_lo) out_val = OUT_MIN;
    else out_val = {~q[OUT_W-1], q[OUT_W-2:0]};
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      s1_u  <= tsum[U_W-1:0];
      s1_hi <= (tval >= OUT_BIAS);
      s1_lo <= (tval < OUT_BIAS_NEG);
      curve <= out_val;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cubic_bspline_forward_difference.sv
`default_nettype none

// The first curve point of a segment follows its closing control point through
// the four setup steps of the control store and the output registers; the
// others follow one per cycle while the output is not stalled. A closing point
// blocks the input for the setup steps and one emit step per curve point,
// longer on stalls; other points do not. Synchronous active-high reset clears
// the sequencer, point count, valid flags and the registers to N = 8, h = 1/8.

module cubic_bspline_forward_difference import cbfd_pkg::*; #(
  parameter int COORD_WIDTH       = 16,
  parameter int MAX_SEGMENT_STEPS = 63
) (
  input  logic          clk,
  input  logic          rst,
  cbfd_cfg_if.sink      cfg,
  cbfd_point_if.sink    points,
  cbfd_curve_if.source  curve
);

  localparam int CW = $clog2(MAX_SEGMENT_STEPS + 1);

  logic [STEPS_W-1:0] segment_steps;
  logic [FRAC_W-1:0]  step_fraction;
  logic [SEEN_W-1:0]  points_seen;
  logic [SEEN_W-1:0]  points_seen_next;
  logic [CW-1:0]      n_eff;
  logic [HALF_W-1:0]  h2, h3;
  logic [HALF_W-1:0]  hmul_a;
  logic [HALF_W+FRAC_W-1:0] hmul;
  logic               accept;
  logic               seg_start;
  logic               adv;
  logic               s1_valid, s1_last;
  logic               out_valid, out_last;
  seq_ctrl_t          ctrl;
  lane_ctrl_t         lane_ctrl;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_steps <= STEPS_RESET;
      step_fraction <= FRACTION_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SEGMENT_STEPS: segment_steps <= cfg.data[STEPS_W-1:0];
        REG_STEP_FRACTION: step_fraction <= cfg.data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = (segment_steps > STEPS_W'(MAX_SEGMENT_STEPS)) ?
                 CW'(MAX_SEGMENT_STEPS) : segment_steps[CW-1:0];

  // input beat and segment detection
  assign points.ready = ctrl.in_ready;
  assign accept       = points.valid && points.ready;
  assign seg_start    = accept && !points.start_curve && (points_seen == SEEN_FULL);

  always_comb begin
    points_seen_next = points_seen;
    if (accept) begin
      if (points.start_curve) points_seen_next = SEEN_ONE;
      else if (points_seen != SEEN_FULL) points_seen_next = points_seen + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) points_seen <= '0;
    else points_seen <= points_seen_next;
  end

  // step powers h^2 and truncated h^3
  assign hmul_a = (ctrl.scal_op == S_H2) ? HALF_W'(step_fraction) : h2;
  assign hmul   = hmul_a * step_fraction;

  always_ff @(posedge clk) begin
    case (ctrl.scal_op)
      S_H2:    h2 <= hmul[HALF_W-1:0];
      S_H3:    h3 <= hmul[HALF_W+FRAC_W-1:FRAC_W];
      default: ;
    endcase
  end

  cbfd_seq #(
    .MAX_SEGMENT_STEPS (MAX_SEGMENT_STEPS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .seg_start (seg_start),
    .adv       (adv),
    .n_eff     (n_eff),
    .ctrl      (ctrl)
  );

  assign lane_ctrl.op   = ctrl.lane_op;
  assign lane_ctrl.load = accept;
  assign lane_ctrl.adv  = adv;

  cbfd_lane #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_lane_x (
    .clk   (clk),
    .ctrl  (lane_ctrl),
    .h     (step_fraction),
    .h2    (h2),
    .h3    (h3),
    .point (points.point_x),
    .curve (curve.curve_x)
  );

  cbfd_lane #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_lane_y (
    .clk   (clk),
    .ctrl  (lane_ctrl),
    .h     (step_fraction),
    .h2    (h2),
    .h3    (h3),
    .point (points.point_y),
    .curve (curve.curve_y)
  );

  // two-stage output pipe, advanced when the output register is free
  assign adv = !out_valid || curve.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= ctrl.emit;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last  <= ctrl.last;
      out_last <= s1_last;
    end
  end

  assign curve.valid           = out_valid;
  assign curve.last_of_segment = out_last;

endmodule

`default_nettype wire

FILE: rtl/cbfd_check.sv
`default_nettype none

module cbfd_check import cbfd_pkg::*; (
  input wire              clk,
  input wire              rst,
  input wire              in_valid,
  input wire              in_ready,
  input wire              in_start,
  input wire              out_valid,
  input wire              out_ready,
  input wire [OUT_W-1:0]  out_x,
  input wire [OUT_W-1:0]  out_y,
  input wire              out_last
);

  logic [SEEN_W-1:0] seen;
  logic [SEEN_W-1:0] seen_next;
  logic              in_beat;

  assign in_beat = in_valid && in_ready;

  // own count of stored control points
  always_comb begin
    seen_next = seen;
    if (in_beat) begin
      if (in_start) seen_next = SEEN_ONE;
      else if (seen != SEEN_FULL) seen_next = seen + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) seen <= '0;
    else seen <= seen_next;
  end

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_last))
    else $error("curve beat changed while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("curve valid after reset");

  // a segment-closing point starts setup and blocks the input
  a_seg_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat && !in_start && (seen == SEEN_FULL) |=> !in_ready)
    else $error("input ready during segment setup");

  // points of one segment leave without gaps
  a_seg_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a segment");

endmodule

bind cubic_bspline_forward_difference cbfd_check u_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (points.valid),
  .in_ready  (points.ready),
  .in_start  (points.start_curve),
  .out_valid (curve.valid),
  .out_ready (curve.ready),
  .out_x     (curve.curve_x),
  .out_y     (curve.curve_y),
  .out_last  (curve.last_of_segment)
);

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cbfd_pkg::*;

  localparam int MAX_STEPS       = 63;
  // covers a closing point at the largest N with margin
  localparam int SETTLE_CYCLES   = MAX_STEPS + 20;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int NUM_PHASES      = 9;
  localparam int HOLD_PHASE      = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = 4'd15;

  localparam longint Q_DIVISOR = 64'sd100663296;
  localparam longint Q_HI      = 64'sd8388607;
  localparam longint Q_LO      = -64'sd8388608;

  typedef struct packed {
    longint pos;
    longint d1;
    longint d2;
    longint d3;
  } fd_lane_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    last;
  } curve_beat_t;

  typedef struct {
    logic signed [15:0]      x;
    logic signed [15:0]      y;
    logic                    start;
    logic                    typed;
    logic signed [OUT_W-1:0] tx;
    logic signed [OUT_W-1:0] ty;
  } point_row_t;

  logic clk;
  logic rst;

  cbfd_point_if #(.COORD_WIDTH(16)) point_ch ();
  cbfd_curve_if                     curve_ch ();
  cbfd_cfg_if                       cfg_ch ();

  cubic_bspline_forward_difference DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .points (point_ch),
    .curve  (curve_ch)
  );

  // phase plan: steps of -1 means a random N with h = 1/N
  int phase_steps [NUM_PHASES] = '{1, 63, 0, 5, 63, 2, -1, -1, 8};
  int phase_frac  [NUM_PHASES] = '{65535, 1040, 12345, 0, 65535, 32768, -1, -1, 8192};
  int phase_items [NUM_PHASES] = '{60, 25, 60, 50, 12, 60, 60, 60, 90};
  int phase_quiet [NUM_PHASES] = '{0, 0, 0, 0, 0, 0, 0, 1, 0};

  // shadow of the block state
  logic [STEPS_W-1:0] seg_steps;
  logic [FRAC_W-1:0]  step_h;
  logic signed [15:0] hist_x [3];
  logic signed [15:0] hist_y [3];
  int                 stored_points;

  curve_beat_t pending_curve_q [$];
  point_row_t  directed_rows [$];

  // known-answer tag that travels with the offered beat
  logic                    offer_typed;
  logic signed [OUT_W-1:0] offer_tx;
  logic signed [OUT_W-1:0] offer_ty;

  int error_count;
  int idle_cycles;
  bit quiet;
  bit hold_off_req;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // floor(acc / (6 * 2^24)), saturated to Q16.8
  function automatic logic signed [OUT_W-1:0] to_q16_8(input longint acc);
    longint q;
    q = acc / Q_DIVISOR;
    if ((acc % Q_DIVISOR) != 0 && acc < 0) q = q - 1;
    if (q > Q_HI) q = Q_HI;
    if (q < Q_LO) q = Q_LO;
    return q[OUT_W-1:0];
  endfunction

  // power-basis coefficients times six, turned into difference accumulators
  function automatic fd_lane_t lane_setup(input longint p0, input longint p1,
                                          input longint p2, input longint p3,
                                          input longint h, input longint h2,
                                          input longint h3);
    longint a, b, c, d;
    fd_lane_t l;
    a = -p0 + 3 * p1 - 3 * p2 + p3;
    b = 3 * p0 - 6 * p1 + 3 * p2;
    c = -3 * p0 + 3 * p2;
    d = p0 + 4 * p1 + p2;
    l.pos = d << 32;
    l.d1  = a * h3 + b * h2 + ((c * h) << 16);
    l.d2  = 6 * a * h3 + 2 * b * h2;
    l.d3  = 6 * a * h3;
    return l;
  endfunction

  // take one control point; a closing point queues the segment's curve points
  task automatic trace_segment(input logic signed [15:0] px, input logic signed [15:0] py,
                               input logic start, input logic typed,
                               input logic signed [OUT_W-1:0] tx,
                               input logic signed [OUT_W-1:0] ty);
    longint h, h2, h3;
    int n, k;
    fd_lane_t lx, ly;
    curve_beat_t beat;
    if (start) begin
      for (k = 0; k < 3; k++) begin
        hist_x[k] = '0;
        hist_y[k] = '0;
      end
      stored_points = 0;
    end
    if (stored_points >= 3) begin
      h  = step_h;
      h2 = h * h;
      h3 = (h2 * h) >> 16;
      n  = seg_steps;
      if (n > MAX_STEPS) n = MAX_STEPS;
      lx = lane_setup(hist_x[0], hist_x[1], hist_x[2], px, h, h2, h3);
      ly = lane_setup(hist_y[0], hist_y[1], hist_y[2], py, h, h2, h3);
      for (k = 0; k <= n; k++) begin
        beat.x    = typed ? tx : to_q16_8(lx.pos);
        beat.y    = typed ? ty : to_q16_8(ly.pos);
        beat.last = (k == n);
        pending_curve_q.insert(pending_curve_q.size(), beat);
        lx.pos = lx.pos + lx.d1;
        lx.d1  = lx.d1 + lx.d2;
        lx.d2  = lx.d2 + lx.d3;
        ly.pos = ly.pos + ly.d1;
        ly.d1  = ly.d1 + ly.d2;
        ly.d2  = ly.d2 + ly.d3;
      end
    end
    hist_x[0] = hist_x[1];
    hist_x[1] = hist_x[2];
    hist_x[2] = px;
    hist_y[0] = hist_y[1];
    hist_y[1] = hist_y[2];
    hist_y[2] = py;
    if (stored_points < 3) stored_points++;
  endtask

  task automatic report_mismatch(input string field, input int exp_val, input int act_val);
    error_count++;
    $display("%0t ns: %s expected %0d, got %0d", $time, field, exp_val, act_val);
  endtask

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic signed [15:0] pick_coord();
    logic signed [15:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = 16'($urandom);
      4, 5, 6:    v = 16'($urandom_range(400)) - 16'sd200;
      default: begin
        case ($urandom_range(3))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // watch all three channels, predict on accepted points, check curve beats
  always @(posedge clk) begin : beat_monitor
    logic progress;
    curve_beat_t exp_beat;
    if (rst) begin
      seg_steps     = STEPS_RESET;
      step_h        = FRACTION_RESET;
      hist_x        = '{default: '0};
      hist_y        = '{default: '0};
      stored_points = 0;
      idle_cycles   = 0;
    end else begin
      progress = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        progress = 1'b1;
        case (cfg_ch.index)
          REG_SEGMENT_STEPS: seg_steps = cfg_ch.data[STEPS_W-1:0];
          REG_STEP_FRACTION: step_h = cfg_ch.data;
          default: ;
        endcase
      end
      if (point_ch.valid && point_ch.ready) begin
        progress = 1'b1;
        trace_segment(point_ch.point_x, point_ch.point_y, point_ch.start_curve,
                      offer_typed, offer_tx, offer_ty);
      end
      if (curve_ch.valid && curve_ch.ready) begin
        progress = 1'b1;
        if (pending_curve_q.size() == 0) begin
          error_count++;
          $display("%0t ns: curve beat with nothing pending (x %0d, y %0d)",
                   $time, curve_ch.curve_x, curve_ch.curve_y);
        end else begin
          exp_beat = pending_curve_q.pop_front();
          if (curve_ch.curve_x !== exp_beat.x)
            report_mismatch("curve_x", exp_beat.x, curve_ch.curve_x);
          if (curve_ch.curve_y !== exp_beat.y)
            report_mismatch("curve_y", exp_beat.y, curve_ch.curve_y);
          if (curve_ch.last_of_segment !== exp_beat.last)
            report_mismatch("last_of_segment", exp_beat.last, curve_ch.last_of_segment);
        end
      end
      // watchdog on cycles without any beat
      if (progress) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t ns: no beat for %0d cycles", $time, idle_cycles);
          $display("cubic_bspline_forward_difference: mismatch");
          $finish;
        end
      end
    end
  end

  // curve sink: random ready pattern plus the one long hold-off
  initial begin : curve_sink
    int run_left;
    int stall_left;
    curve_ch.ready = 1'b0;
    run_left   = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
        run_left     = 0;
      end
      if (stall_left > 0) begin
        curve_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        curve_ch.ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(12, 1);
          stall_left = pick_gap();
        end
      end
    end
  end

  // offer one control point and hold it until accepted, then maybe idle
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic start, input logic typed,
                            input logic signed [OUT_W-1:0] tx,
                            input logic signed [OUT_W-1:0] ty);
    int gap;
    point_ch.valid       <= 1'b1;
    point_ch.point_x     <= x;
    point_ch.point_y     <= y;
    point_ch.start_curve <= start;
    offer_typed          <= typed;
    offer_tx             <= tx;
    offer_ty             <= ty;
    do @(posedge clk); while (!point_ch.ready);
    gap = pick_gap();
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write; valid stays up until the caller lowers it
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // stop offering, wait for every pending curve point, let the block go idle
  task automatic wait_drained();
    point_ch.valid <= 1'b0;
    while (pending_curve_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_row(input logic signed [15:0] x, input logic signed [15:0] y,
                         input logic start, input logic typed,
                         input logic signed [OUT_W-1:0] tx,
                         input logic signed [OUT_W-1:0] ty);
    point_row_t r;
    r.x = x; r.y = y; r.start = start; r.typed = typed; r.tx = tx; r.ty = ty;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  // stimulus
  initial begin : point_source
    int p, n, h, sent, len, i;
    logic noisy, start;
    logic [CFG_DATA_W-1:0] steps_word;

    rst                  = 1'b1;
    point_ch.valid       = 1'b0;
    point_ch.point_x     = '0;
    point_ch.point_y     = '0;
    point_ch.start_curve = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    offer_typed          = 1'b0;
    offer_tx             = '0;
    offer_ty             = '0;
    error_count          = 0;
    quiet                = 1'b0;
    hold_off_req         = 1'b0;

    // directed rows at the reset setting (N = 8, h = 1/8)
    // identical points give a flat segment at p * 256
    add_row(16'sd0, 16'sd0, 1'b0, 1'b0, 0, 0);
    add_row(16'sd0, 16'sd0, 1'b0, 1'b0, 0, 0);
    add_row(16'sd0, 16'sd0, 1'b0, 1'b0, 0, 0);
    add_row(16'sd0, 16'sd0, 1'b0, 1'b1, 0, 0);
    add_row(16'sh7FFF, 16'sh8000, 1'b1, 1'b0, 0, 0);
    add_row(16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 0, 0);
    add_row(16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 0, 0);
    add_row(16'sh7FFF, 16'sh8000, 1'b0, 1'b1, 24'sd8388352, -24'sd8388608);
    add_row(16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 0, 0);
    add_row(16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 0, 0);
    add_row(16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 0, 0);
    add_row(16'sh8000, 16'sh7FFF, 1'b0, 1'b1, -24'sd8388608, 24'sd8388352);
    add_row(16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 0, 0);
    add_row(16'sh8000, 16'sh8000, 1'b0, 1'b0, 0, 0);
    add_row(16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 0, 0);
    add_row(-16'sd1, 16'sd1, 1'b0, 1'b0, 0, 0);
    add_row(16'sd21845, -16'sd21846, 1'b0, 1'b0, 0, 0);
    // new curve with a full history: the next three points stay silent
    add_row(16'sd100, -16'sd100, 1'b1, 1'b0, 0, 0);
    add_row(16'sd100, -16'sd100, 1'b0, 1'b0, 0, 0);
    add_row(16'sd100, -16'sd100, 1'b0, 1'b0, 0, 0);
    add_row(16'sd100, -16'sd100, 1'b0, 1'b1, 24'sd25600, -24'sd25600);
    add_row(-16'sd1, -16'sd1, 1'b1, 1'b0, 0, 0);
    add_row(-16'sd1, -16'sd1, 1'b0, 1'b0, 0, 0);
    add_row(-16'sd1, -16'sd1, 1'b0, 1'b0, 0, 0);
    add_row(-16'sd1, -16'sd1, 1'b0, 1'b1, -24'sd256, -24'sd256);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_point(directed_rows[r].x, directed_rows[r].y, directed_rows[r].start,
                 directed_rows[r].typed, directed_rows[r].tx, directed_rows[r].ty);

    // random phases, each under its own register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (phase_steps[p] < 0) begin
        n = $urandom_range(MAX_STEPS, 1);
        h = (n == 1) ? 65535 : 65536 / n;
      end else begin
        n = phase_steps[p];
        h = phase_frac[p];
      end
      // upper bits of the steps word are junk that the block must drop
      steps_word = 16'($urandom);
      steps_word[STEPS_W-1:0] = n[STEPS_W-1:0];
      write_register(REG_SEGMENT_STEPS, steps_word);
      write_register(REG_STEP_FRACTION, h[CFG_DATA_W-1:0]);
      if (p % 2 == 0)
        write_register(CFG_INDEX_W'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)),
                       16'($urandom));
      cfg_ch.valid <= 1'b0;

      quiet = (phase_quiet[p] != 0);
      if (p == HOLD_PHASE) hold_off_req = 1'b1;

      // mostly well-formed curves, some noise on start_curve
      sent = 0;
      while (sent < phase_items[p]) begin
        noisy = ($urandom_range(7) == 0);
        len   = noisy ? $urandom_range(5, 1) : $urandom_range(10, 4);
        for (i = 0; i < len; i++) begin
          start = noisy ? ($urandom_range(2) == 0) : (i == 0);
          send_point(pick_coord(), pick_coord(), start, 1'b0, 0, 0);
          sent++;
        end
      end
      quiet = 1'b0;
    end

    wait_drained();
    if (error_count == 0 && pending_curve_q.size() == 0) begin
      $display("cubic_bspline_forward_difference: match");
    end else begin
      $display("cubic_bspline_forward_difference: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cbfd_pkg.sv
rtl/cbfd_if.sv
rtl/cbfd_seq.sv
rtl/cbfd_lane.sv
rtl/cubic_bspline_forward_difference.sv
rtl/cbfd_check.sv
verif/tb_top.sv
